// File: design/light_sensor_autogain_lux_assert.svh
// assertion macros for the light sensor auto-gain lux block
`ifndef LIGHT_SENSOR_AUTOGAIN_LUX_ASSERT_SVH
`define LIGHT_SENSOR_AUTOGAIN_LUX_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define LSAL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("light sensor autogain: assertion failed");

// next-cycle implication, clocked on aclk, off during reset
`define LSAL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("light sensor autogain: assertion failed");

`endif

// File: design/lsal_pkg.sv
// shared types, level table and constants of the light sensor auto-gain lux block
`timescale 1ns / 1ps

package lsal_pkg;

    localparam int LSAL_LEVELS  = 5;
    localparam int LSAL_LEVEL_W = 3;
    localparam int LSAL_ROWS    = 5;
    localparam int LSAL_RECIP_W = 26;
    localparam int LSAL_QDEPTH  = 2;
    localparam int LSAL_QPTR_W  = (LSAL_QDEPTH > 1) ? $clog2(LSAL_QDEPTH) : 1;
    localparam int LSAL_QCNT_W  = $clog2(LSAL_QDEPTH + 1);

    localparam int LSAL_S_TDATA_W = 64;
    localparam int LSAL_M_TDATA_W = 56;

    // dn40 coefficients, q16
    localparam logic signed [17:0] LSAL_COEF_R = 18'sd9568;
    localparam logic signed [17:0] LSAL_COEF_G = 18'sd65536;
    localparam logic signed [17:0] LSAL_COEF_B = -18'sd29753;

    localparam logic signed [23:0] LSAL_LUX_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] LSAL_LUX_MIN = 24'sh800000;

    typedef struct packed {
        logic [1:0]              gain;
        logic [7:0]              itime;
        logic [15:0]             lower;     // zero means no lower limit
        logic [15:0]             upper;     // zero means no upper limit
        logic [LSAL_RECIP_W-1:0] recip;     // round(320 * 2^24 / (ms * gain)), q24
        logic                    short_int; // integration under 150 ms
        logic [15:0]             sat75;     // clear count saturation threshold, used only for short integration
    } lsal_row_t;

    // ms = floor((256 - itime) * 12 / 5): 614 for 0x00, 153 for 0xc0
    localparam lsal_row_t LSAL_TABLE [LSAL_ROWS] = '{
        '{2'd3, 8'h00, 16'd0,     16'd20000, 26'd145730,   1'b0, 16'd65535},
        '{2'd3, 8'hC0, 16'd4990,  16'd63000, 26'd584827,   1'b0, 16'd65535},
        '{2'd2, 8'hC0, 16'd16790, 16'd63000, 26'd2193100,  1'b0, 16'd65535},
        '{2'd1, 8'hC0, 16'd15840, 16'd63000, 26'd8772401,  1'b0, 16'd65535},
        '{2'd0, 8'hC0, 16'd15840, 16'd0,     26'd35089602, 1'b0, 16'd65535}
    };

    typedef struct packed {
        logic [15:0]             red;
        logic [15:0]             green;
        logic [15:0]             blue;
        logic [15:0]             clear;
        logic [LSAL_LEVEL_W-1:0] lvl;     // level that took the sample
        logic [LSAL_LEVEL_W-1:0] nxt;     // level in force afterwards
        logic                    changed;
    } lsal_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lsal_q_status_t;

    typedef struct packed {
        logic signed [23:0]      lux_q4;
        logic                    lux_valid;
        logic [15:0]             ir_estimate;
        logic                    saturated;
        logic [LSAL_LEVEL_W-1:0] level_now;
        logic [1:0]              gain_code;
        logic [7:0]              integration_code;
    } lsal_result_t;

    // levels past the table use its last row
    function automatic lsal_row_t lsal_row(input logic [LSAL_LEVEL_W-1:0] lvl);
        lsal_row_t r;
        if (32'(lvl) < LSAL_ROWS) begin
            r = LSAL_TABLE[lvl];
        end else begin
            r = LSAL_TABLE[LSAL_ROWS-1];
        end
        return r;
    endfunction

endpackage

// File: design/lsal_front.sv
// front end: takes samples, runs the auto-gain decision and queues the work
`timescale 1ns / 1ps

module lsal_front
    import lsal_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [LSAL_S_TDATA_W-1:0] s_tdata,
    input  lsal_q_status_t            q_status,
    output logic                      q_push,
    output lsal_item_t                q_item
);

    logic [LSAL_LEVEL_W-1:0] agc_reg, agc_next;
    logic                    reread_reg, reread_next;
    logic [LSAL_LEVEL_W-1:0] lvl;
    logic [15:0]             clear;
    lsal_row_t               row;
    logic                    step_up, step_down;

    assign s_tready = !q_status.full;
    assign q_push   = s_tvalid && s_tready;
    assign clear    = s_tdata[63:48];

    always_comb begin
        lvl = (agc_reg > LSAL_LEVEL_W'(LSAL_LEVELS - 1)) ?
              LSAL_LEVEL_W'(LSAL_LEVELS - 1) : agc_reg;
        row = lsal_row(lvl);
        step_up   = (row.upper != 16'd0) && (clear > row.upper) &&
                    (lvl < LSAL_LEVEL_W'(LSAL_LEVELS - 1));
        step_down = (row.lower != 16'd0) && (clear < row.lower) &&
                    (lvl != '0);

        q_item.red     = s_tdata[15:0];
        q_item.green   = s_tdata[31:16];
        q_item.blue    = s_tdata[47:32];
        q_item.clear   = clear;
        q_item.lvl     = lvl;
        q_item.nxt     = lvl;
        q_item.changed = 1'b0;
        reread_next    = 1'b0;
        // the sample after a level change is the re-read and never steps
        if (!reread_reg) begin
            priority if (step_up) begin
                q_item.nxt = lvl + LSAL_LEVEL_W'(1);
            end else if (step_down) begin
                q_item.nxt = lvl - LSAL_LEVEL_W'(1);
            end
            q_item.changed = step_up || step_down;
            reread_next    = step_up || step_down;
        end
        agc_next = q_item.nxt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            agc_reg    <= '0;
            reread_reg <= 1'b0;
        end else if (q_push) begin
            agc_reg    <= agc_next;
            reread_reg <= reread_next;
        end
    end

endmodule

// File: design/lsal_fifo.sv
// short queue of classified samples between front and back end
`timescale 1ns / 1ps

module lsal_fifo
    import lsal_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lsal_item_t     push_item,
    input  logic           pop,
    output lsal_item_t     head_item,
    output lsal_q_status_t status
);

    lsal_item_t             mem [LSAL_QDEPTH];
    logic [LSAL_QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LSAL_QCNT_W-1:0] count_reg;

    function automatic logic [LSAL_QPTR_W-1:0] ptr_inc(input logic [LSAL_QPTR_W-1:0] p);
        logic [LSAL_QPTR_W-1:0] n;
        if (p == LSAL_QPTR_W'(LSAL_QDEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + LSAL_QPTR_W'(1);
        end
        return n;
    endfunction

    assign head_item    = mem[rd_ptr_reg];
    assign status.full  = (count_reg == LSAL_QCNT_W'(LSAL_QDEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + LSAL_QCNT_W'(1);
                2'b01:   count_reg <= count_reg - LSAL_QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: design/lsal_back.sv
// back end: ir estimate, dn40 lux sequencer and output register
`timescale 1ns / 1ps

module lsal_back
    import lsal_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  lsal_q_status_t q_status,
    input  lsal_item_t     head_item,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output lsal_result_t   m_result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_IR   = 3'd1;
    localparam logic [2:0] ST_MAC  = 3'd2;
    localparam logic [2:0] ST_ABS  = 3'd3;
    localparam logic [2:0] ST_MUL0 = 3'd4;
    localparam logic [2:0] ST_MUL1 = 3'd5;
    localparam logic [2:0] ST_RND  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]         st_reg, st_next;
    lsal_item_t         item_reg;
    logic [15:0]        ir_reg;
    logic               sat_reg;
    logic [1:0]         k_reg;
    logic signed [33:0] acc_reg;
    logic               neg_reg;
    logic [32:0]        mag_reg;
    logic [59:0]        prod_reg;
    logic signed [23:0] lux_reg;
    lsal_result_t       out_reg;
    logic               out_valid_reg;

    lsal_row_t          row_cur, row_nxt;
    logic [17:0]        sum3, sum_diff;
    logic [16:0]        half;
    logic [15:0]        ir_calc;
    logic [15:0]        chan;
    logic signed [17:0] coef;
    logic signed [16:0] diff;
    logic signed [34:0] mac_prod;
    logic [42:0]        pp_lo;
    logic [41:0]        pp_hi;
    logic [59:0]        rnd;
    logic [23:0]        rmag;
    logic signed [23:0] lux_calc;
    logic               load_out;

    assign row_cur  = lsal_row(item_reg.lvl);
    assign row_nxt  = lsal_row(item_reg.nxt);
    assign q_pop    = (st_reg == ST_IDLE) && !q_status.empty;
    assign load_out = (st_reg == ST_OUT) && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_comb begin
        sum3     = 18'(item_reg.red) + 18'(item_reg.green) + 18'(item_reg.blue);
        sum_diff = sum3 - 18'(item_reg.clear);
        half     = sum_diff[17:1];
        if (sum3 > 18'(item_reg.clear)) begin
            ir_calc = half[16] ? 16'hFFFF : half[15:0];
        end else begin
            ir_calc = '0;
        end

        // one coefficient term per step through a shared multiplier
        unique case (k_reg)
            2'd0: begin
                chan = item_reg.red;
                coef = LSAL_COEF_R;
            end
            2'd1: begin
                chan = item_reg.green;
                coef = LSAL_COEF_G;
            end
            default: begin
                chan = item_reg.blue;
                coef = LSAL_COEF_B;
            end
        endcase
        diff     = $signed({1'b0, chan}) - $signed({1'b0, ir_reg});
        mac_prod = 35'(coef) * 35'(diff);

        // 33 x 26 magnitude product in two halves
        pp_lo = 43'(mag_reg[16:0]) * 43'(row_cur.recip);
        pp_hi = 42'(mag_reg[32:17]) * 42'(row_cur.recip);

        // round half away from zero on the magnitude, then clamp
        rnd  = prod_reg + (60'd1 << 35);
        rmag = rnd[59:36];
        if (neg_reg) begin
            lux_calc = (rmag > 24'h800000) ? LSAL_LUX_MIN : $signed(24'(-rmag));
        end else begin
            lux_calc = (rmag > 24'h7FFFFF) ? LSAL_LUX_MAX : $signed(rmag);
        end
        if (item_reg.changed) begin
            lux_calc = '0;
        end
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (!q_status.empty) st_next = ST_IR;
            ST_IR:   st_next = ST_MAC;
            ST_MAC:  if (k_reg == 2'd2) st_next = ST_ABS;
            ST_ABS:  st_next = ST_MUL0;
            ST_MUL0: st_next = ST_MUL1;
            ST_MUL1: st_next = ST_RND;
            ST_RND:  st_next = ST_OUT;
            ST_OUT:  if (load_out) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (st_reg)
            ST_IDLE: begin
                item_reg <= head_item;
                k_reg    <= '0;
                acc_reg  <= '0;
            end
            ST_IR: begin
                ir_reg  <= ir_calc;
                sat_reg <= row_cur.short_int && (item_reg.clear > row_cur.sat75);
            end
            ST_MAC: begin
                acc_reg <= acc_reg + 34'(mac_prod);
                k_reg   <= k_reg + 2'd1;
            end
            ST_ABS: begin
                neg_reg <= acc_reg[33];
                mag_reg <= acc_reg[33] ? 33'(-acc_reg) : 33'(acc_reg);
            end
            ST_MUL0: prod_reg <= 60'(pp_lo);
            ST_MUL1: prod_reg <= prod_reg + (60'(pp_hi) << 17);
            ST_RND:  lux_reg  <= lux_calc;
            default: begin
                if (load_out) begin
                    out_reg.lux_q4           <= lux_reg;
                    out_reg.lux_valid        <= !item_reg.changed;
                    out_reg.ir_estimate      <= ir_reg;
                    out_reg.saturated        <= sat_reg;
                    out_reg.level_now        <= item_reg.nxt;
                    out_reg.gain_code        <= row_nxt.gain;
                    out_reg.integration_code <= row_nxt.itime;
                end
            end
        endcase
    end

endmodule

// File: design/light_sensor_autogain_lux.sv
// top level of the light sensor auto-gain lux block
// Each beat on s_ carries one raw red, green, blue and clear sample and yields
// one beat on m_ with the ir estimate, dn40 lux in q4, the auto-gain level now
// in force and the gain and integration codes to program for it. The front
// end takes a sample and decides the level step at once, so the level and
// codes follow the sample order exactly; it holds samples in a two-entry
// queue. The back end works through ir, three coefficient steps through one
// shared 18 x 17 multiplier, magnitude, two half products of the 33 x 26
// lux product, rounding and the output register, one sample at a time. A
// sample that changes the level returns lux 0 with m_tuser low, and the
// next sample is the re-read.
`timescale 1ns / 1ps
`include "light_sensor_autogain_lux_assert.svh"

module light_sensor_autogain_lux
    import lsal_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // red[15:0], green[31:16], blue[47:32], clear[63:48]
    input  logic [LSAL_S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // lux_q4[23:0], ir_estimate[39:24], saturated[40], level_now[43:41],
    // gain_code[45:44], integration_code[53:46], zero pad[55:54]
    output logic [LSAL_M_TDATA_W-1:0] m_tdata,
    // lux_valid
    output logic                      m_tuser
);

    lsal_q_status_t q_status;
    logic           q_push, q_pop;
    lsal_item_t     q_item, head_item;
    lsal_result_t   result;
    lsal_row_t      out_row;

    lsal_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    lsal_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head_item (head_item),
        .status    (q_status)
    );

    lsal_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .head_item (head_item),
        .q_pop     (q_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (result)
    );

    assign m_tdata = {2'b00, result.integration_code, result.gain_code, result.level_now,
                      result.saturated, result.ir_estimate, result.lux_q4};
    assign m_tuser = result.lux_valid;

    // table row of the reported level
    assign out_row = lsal_row(m_tdata[43:41]);

    // a level change forces the following accepted sample to be a plain re-read
    `LSAL_ASSERT_NEXT(a_reread_after_change, q_push && q_item.changed, !(q_push && q_item.changed))
    // no lux is reported on a level-change beat
    `LSAL_ASSERT_IMP(a_no_lux_on_change, m_tvalid && !m_tuser, m_tdata[23:0] == 24'd0)
    // reported level stays in range and its gain code matches the table
    `LSAL_ASSERT_IMP(a_level_range, m_tvalid, m_tdata[43:41] <= LSAL_LEVEL_W'(LSAL_LEVELS - 1))
    `LSAL_ASSERT_IMP(a_gain_matches, m_tvalid, m_tdata[45:44] == out_row.gain)

endmodule

// File: tb/sv/tb_light_sensor_autogain_lux.sv
// testbench for the light sensor auto-gain lux block: directed and random samples, scoreboard
`timescale 1ns / 1ps

module tb_light_sensor_autogain_lux;
    import lsal_pkg::*;

    localparam int N_RANDOM = 1080;

    // per-level gain code, integration code and clear-count window (0 = no limit)
    localparam logic [1:0]  LVL_GAIN  [LSAL_ROWS] = '{2'd3, 2'd3, 2'd2, 2'd1, 2'd0};
    localparam logic [7:0]  LVL_ITIME [LSAL_ROWS] = '{8'h00, 8'hC0, 8'hC0, 8'hC0, 8'hC0};
    localparam logic [15:0] LVL_LOWER [LSAL_ROWS] = '{16'd0, 16'd4990, 16'd16790, 16'd15840,
                                                      16'd15840};
    localparam logic [15:0] LVL_UPPER [LSAL_ROWS] = '{16'd20000, 16'd63000, 16'd63000,
                                                      16'd63000, 16'd0};
    localparam int unsigned GAIN_FACTOR [4] = '{1, 4, 16, 60};

    typedef enum int {RX_OPEN, RX_COIN, RX_RUNS, RX_SPARSE} rx_mode_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    // red[15:0], green[31:16], blue[47:32], clear[63:48]
    logic [LSAL_S_TDATA_W-1:0] s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    // lux_q4[23:0], ir_estimate[39:24], saturated[40], level_now[43:41],
    // gain_code[45:44], integration_code[53:46], zero pad[55:54]
    logic [LSAL_M_TDATA_W-1:0] m_tdata;
    // lux_valid
    logic                      m_tuser;

    // predictor state
    int unsigned  agc_level = 0;
    bit           reread_owed = 1'b0;
    lsal_result_t pending_readings[$];

    int unsigned samples_sent = 0;
    int unsigned directed_sent = 0;
    int unsigned results_checked = 0;
    int unsigned level_changes = 0;
    int unsigned ir_clamps = 0;
    int unsigned negative_lux = 0;
    logic [7:0]  levels_seen = 8'd1;
    int unsigned mismatches = 0;
    int unsigned burst_left = 0;

    light_sensor_autogain_lux u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned row_of_level(input int unsigned lvl);
        return (lvl < LSAL_ROWS) ? lvl : LSAL_ROWS - 1;
    endfunction

    // expected result of one sample; advances the auto-gain state
    function automatic lsal_result_t compute_reading(input logic [15:0] r, input logic [15:0] g,
                                                     input logic [15:0] b, input logic [15:0] c);
        int unsigned lvl, nxt, row, nrow, sum, irv, ms, cnt, sat, sat75, d;
        longint unsigned recip, mag;
        longint s, prod, luxv;
        bit changed;
        lsal_result_t res;
        lvl = (agc_level > LSAL_LEVELS - 1) ? LSAL_LEVELS - 1 : agc_level;
        row = row_of_level(lvl);
        nxt = lvl;
        changed = 1'b0;
        if (reread_owed) begin
            reread_owed = 1'b0;
        end else begin
            if (LVL_UPPER[row] != 0 && c > LVL_UPPER[row] && lvl < LSAL_LEVELS - 1) begin
                nxt = lvl + 1;
            end else if (LVL_LOWER[row] != 0 && c < LVL_LOWER[row] && lvl > 0) begin
                nxt = lvl - 1;
            end
            if (nxt != lvl) begin
                changed = 1'b1;
                reread_owed = 1'b1;
                level_changes++;
            end
        end
        agc_level = nxt;
        levels_seen[nxt] = 1'b1;
        nrow = row_of_level(nxt);

        sum = int'(r) + int'(g) + int'(b);
        irv = (sum > c) ? (sum - c) / 2 : 0;
        if (irv > 65535) begin
            irv = 65535;
            ir_clamps++;
        end

        ms = ((256 - LVL_ITIME[row]) * 12) / 5;
        cnt = 256 - LVL_ITIME[row];
        sat = (cnt > 63) ? 65535 : 1024 * cnt;
        sat75 = (ms < 150) ? sat - sat / 4 : sat;

        luxv = 0;
        if (!changed) begin
            d = ms * GAIN_FACTOR[LVL_GAIN[row]];
            if (d == 0) d = 1;
            recip = ((64'd320 << 24) + d / 2) / d;
            s = 64'sd9568 * (longint'(r) - longint'(irv))
              + 64'sd65536 * (longint'(g) - longint'(irv))
              - 64'sd29753 * (longint'(b) - longint'(irv));
            prod = s * longint'(recip);
            // round half away from zero on the magnitude, then clamp to 24 bits signed
            if (prod < 0) begin
                mag = (longint'(-prod) + (64'd1 << 35)) >> 36;
                luxv = (mag > 64'd8388608) ? -64'sd8388608 : -longint'(mag);
                negative_lux++;
            end else begin
                mag = (longint'(prod) + (64'd1 << 35)) >> 36;
                luxv = (mag > 64'd8388607) ? 64'sd8388607 : longint'(mag);
            end
        end

        res.lux_q4           = luxv[23:0];
        res.lux_valid        = !changed;
        res.ir_estimate      = irv[15:0];
        res.saturated        = (ms < 150 && c > sat75);
        res.level_now        = nxt[LSAL_LEVEL_W-1:0];
        res.gain_code        = LVL_GAIN[nrow];
        res.integration_code = LVL_ITIME[nrow];
        return res;
    endfunction

    task automatic send_sample(input logic [15:0] r, input logic [15:0] g,
                               input logic [15:0] b, input logic [15:0] c);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 3);
                2: gap = $urandom_range(4, 12);
                default: gap = $urandom_range(13, 40);
            endcase
            if (gap > 0) begin
                @(negedge aclk) s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {c, b, g, r};
        do @(posedge aclk); while (!s_tready);
        pending_readings.push_back(compute_reading(r, g, b, c));
        samples_sent++;
        burst_left--;
    endtask

    task automatic test_extremes();
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // level 0, no lower limit
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // steps up, lux invalid
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);  // re-read, no step
    endtask

    task automatic test_ir_edges();
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd30000);  // ir clamps high
        send_sample(16'd10000, 16'd10000, 16'd10001, 16'd30000); // sum one over clear
        send_sample(16'd0, 16'd0, 16'hFFFF, 16'd30000);        // negative lux
    endtask

    // walk the level range up to the top and back down through every window edge
    task automatic test_level_walk();
        logic [15:0] walk [20] = '{16'd63001, 16'd65535, 16'd63001, 16'd63000, 16'd65535,
                                   16'd65535, 16'd65535, 16'd15840, 16'd15839, 16'd0,
                                   16'd15839, 16'd0, 16'd16789, 16'd65535, 16'd4990,
                                   16'd4989, 16'd0, 16'd20000, 16'd20001, 16'd0};
        for (int i = 0; i < 20; i++) begin
            send_sample(walk[i] ^ 16'h5A5A, walk[i] >> 1, ~walk[i], walk[i]);
        end
    endtask

    task automatic test_random();
        int unsigned row, lo, hi, c, r, g, b;
        for (int n = 0; n < N_RANDOM; n++) begin
            row = row_of_level(agc_level);
            lo = LVL_LOWER[row];
            hi = LVL_UPPER[row];
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: c = (hi != 0) ? $urandom_range(hi + 1, 65535)
                                             : $urandom_range(40000, 65535);
                5, 6, 7, 8, 9: c = (lo != 0) ? $urandom_range(0, lo - 1) : $urandom_range(0, 4000);
                10, 11, 12, 13: c = $urandom_range(lo, (hi != 0) ? hi : 65535);
                14, 15, 16: begin
                    case ($urandom_range(0, 3))
                        0: c = (lo != 0) ? lo - 1 : 0;
                        1: c = lo;
                        2: c = (hi != 0) ? hi : 65535;
                        default: c = (hi != 0) ? hi + 1 : 65535;
                    endcase
                end
                default: c = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 4))
                0, 1: begin
                    r = $urandom_range(0, 65535);
                    g = $urandom_range(0, 65535);
                    b = $urandom_range(0, 65535);
                end
                2: begin
                    // channels sum close to clear: ir near zero
                    r = $urandom_range(0, c);
                    g = $urandom_range(0, c - r);
                    b = c - r - g + $urandom_range(0, 3);
                    if (b > 65535) b = 65535;
                end
                3: begin
                    r = $urandom_range(0, c / 3);
                    g = $urandom_range(0, c / 2);
                    b = $urandom_range(0, c / 3);
                end
                default: begin
                    r = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 255);
                    g = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 255);
                    b = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 255);
                end
            endcase
            send_sample(r[15:0], g[15:0], b[15:0], c[15:0]);
        end
        @(negedge aclk) s_tvalid <= 1'b0;
    endtask

    task automatic check_field(input string fname, input longint expv, input longint actv);
        if (expv != actv) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d %s: expected %0d, got %0d", results_checked, fname, expv,
                         actv);
            end
        end
    endtask

    // receiver stall pattern, switching among open, coin-flip, run and sparse modes
    rx_mode_t    rx_mode = RX_OPEN;
    int unsigned rx_mode_left = 0;
    int unsigned rx_run_left = 0;
    bit          rx_run_ready = 1'b0;

    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(40, 400);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_OPEN: m_tready <= 1'b1;
            RX_COIN: m_tready <= 1'($urandom_range(0, 1));
            RX_RUNS: begin
                if (rx_run_left == 0) begin
                    rx_run_ready = !rx_run_ready;
                    rx_run_left = rx_run_ready ? $urandom_range(1, 6) : $urandom_range(1, 20);
                end
                rx_run_left--;
                m_tready <= rx_run_ready;
            end
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        lsal_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result beat with nothing expected: tdata %h tuser %b", m_tdata,
                             m_tuser);
                end
            end else begin
                want = pending_readings.pop_front();
                check_field("lux_q4", $signed(want.lux_q4), $signed(m_tdata[23:0]));
                check_field("lux_valid", want.lux_valid, m_tuser);
                check_field("ir_estimate", want.ir_estimate, m_tdata[39:24]);
                check_field("saturated", want.saturated, m_tdata[40]);
                check_field("level_now", want.level_now, m_tdata[43:41]);
                check_field("gain_code", want.gain_code, m_tdata[45:44]);
                check_field("integration_code", want.integration_code, m_tdata[53:46]);
            end
            results_checked++;
        end
    end

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_ir_edges();
        test_level_walk();
        directed_sent = samples_sent;
        test_random();
        wait (pending_readings.size() == 0);
        repeat (40) @(posedge aclk);
        if (pending_readings.size() != 0) begin
            mismatches++;
        end
        $display("sent %0d samples (%0d directed), checked %0d results, %0d level changes",
                 samples_sent, directed_sent, results_checked, level_changes);
        $display("levels reached %b, ir clamps %0d, negative lux %0d, mismatching fields %0d",
                 levels_seen[LSAL_LEVELS-1:0], ir_clamps, negative_lux, mismatches);
        if (mismatches == 0) begin
            $display("light_sensor_autogain_lux: match");
        end else begin
            $display("light_sensor_autogain_lux: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_readings.size());
        $display("light_sensor_autogain_lux: mismatch");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/lsal_pkg.sv
design/lsal_front.sv
design/lsal_fifo.sv
design/lsal_back.sv
design/light_sensor_autogain_lux.sv
tb/sv/tb_light_sensor_autogain_lux.sv
